/* hdl/dci_pkg.sv */
`default_nettype none

package dci_pkg;

    // Fixed-point format shared by every datapath stage.
    localparam int FRAC_BITS = 16;

    // Pipeline depths of the arithmetic units.
    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = 66;

    // Queue between the front and the back.
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = 2;

    // Configuration register map.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 4'd1;

    localparam logic [30:0] INV_DT_RESET = 31'(60 << FRAC_BITS);
    localparam logic [16:0] GAIN_RESET   = 17'((1 << FRAC_BITS) / 5);

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // One constraint after the front has formed the differences.
    typedef struct packed {
        logic signed [32:0] rx;
        logic signed [32:0] ry;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic [30:0]        inv_mass_a;
        logic [30:0]        inv_mass_b;
        logic [31:0]        inv_mass_sum;
        logic [30:0]        rest_distance;
    } prep_t;

    // One finished result.
    typedef struct packed {
        logic signed [31:0] new_vel_a_x;
        logic signed [31:0] new_vel_a_y;
        logic signed [31:0] new_vel_b_x;
        logic signed [31:0] new_vel_b_y;
        logic               skipped;
    } res_t;

    // Saturating 64-bit signed add.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    // Saturating 64-bit signed subtract.
    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    // Clamp a 65-bit signed value to the 32-bit signed range.
    function automatic logic signed [31:0] clamp32(input logic [64:0] v);
        if (v[64:31] == {34{v[64]}})
            return v[31:0];
        return v[64] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

endpackage

`default_nettype wire

/* hdl/distance_constraint_impulse_core.sv */
`default_nettype none

// Distance constraint velocity impulse for pairs of 2D particles, Baumgarte
// stabilized, in signed Q16.16. Push one constraint per cycle while full is
// low; results come out in order, one per item, while empty is low, and move
// on pop. Throughput is one item per clock while the output queue has room:
// every multiply is a four-stage unit built from 32x32 partial products, and
// the impulse quotient comes from a 64-stage restoring divider that retires
// one quotient bit per stage. Items pass the input queue, the datapath and
// the output queue in that order. The whole datapath holds when the
// two-entry output queue is full. Register 0 is the inverse time step
// (31 bits, reset 60.0), register 1 the correction gain (17 bits, reset 0.2);
// write them only while the block is idle. skipped is high when the
// effective-mass denominator is zero, and the velocities then pass unchanged.
module distance_constraint_impulse_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [31:0]            pos_a_x,
    input  logic signed [31:0]            pos_a_y,
    input  logic signed [31:0]            pos_b_x,
    input  logic signed [31:0]            pos_b_y,
    input  logic signed [31:0]            vel_a_x,
    input  logic signed [31:0]            vel_a_y,
    input  logic signed [31:0]            vel_b_x,
    input  logic signed [31:0]            vel_b_y,
    input  logic [30:0]                   inv_mass_a,
    input  logic [30:0]                   inv_mass_b,
    input  logic [30:0]                   rest_distance,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            new_vel_a_x,
    output logic signed [31:0]            new_vel_a_y,
    output logic signed [31:0]            new_vel_b_x,
    output logic signed [31:0]            new_vel_b_y,
    output logic                          skipped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import dci_pkg::*;

    logic [30:0] inv_dt_reg;
    logic [16:0] gain_reg;
    logic        head_valid;
    prep_t       head;
    logic        adv;
    logic        take;
    logic        bk_valid;
    res_t        bk_res;
    res_t        oq_mem [2];
    logic        oq_wr_ptr_reg;
    logic        oq_rd_ptr_reg;
    logic [1:0]  oq_cnt_reg;
    logic [1:0]  oq_cnt_next;
    logic        oq_full;
    logic        oq_wr;
    logic        oq_rd;
    res_t        oq_head;

    // Configuration registers; every write transfer completes at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_dt_reg <= INV_DT_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INV_DT: inv_dt_reg <= cfg_data[30:0];
                CFG_GAIN:   gain_reg   <= cfg_data[16:0];
                default:    ;
            endcase
        end
    end

    // Front: accepts items, forms differences, buffers them.
    dci_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .pos_a_x       (pos_a_x),
        .pos_a_y       (pos_a_y),
        .pos_b_x       (pos_b_x),
        .pos_b_y       (pos_b_y),
        .vel_a_x       (vel_a_x),
        .vel_a_y       (vel_a_y),
        .vel_b_x       (vel_b_x),
        .vel_b_y       (vel_b_y),
        .inv_mass_a    (inv_mass_a),
        .inv_mass_b    (inv_mass_b),
        .rest_distance (rest_distance),
        .take          (take),
        .head_valid    (head_valid),
        .head          (head)
    );

    // Back: the arithmetic pipeline, held while the output queue is full.
    assign oq_full = oq_cnt_reg == 2'd2;
    assign adv     = ~oq_full;
    assign take    = adv & head_valid;

    dci_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (head_valid),
        .in_data   (head),
        .gain      (gain_reg),
        .inv_dt    (inv_dt_reg),
        .res_valid (bk_valid),
        .res       (bk_res)
    );

    // Two-entry output queue.
    assign oq_wr   = bk_valid & adv;
    assign oq_rd   = pop & ~empty;
    assign empty   = oq_cnt_reg == 2'd0;
    assign oq_head = oq_mem[oq_rd_ptr_reg];

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg + {1'b0, oq_wr} - {1'b0, oq_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= 1'b0;
            oq_rd_ptr_reg <= 1'b0;
            oq_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (oq_wr)
                oq_wr_ptr_reg <= ~oq_wr_ptr_reg;
            if (oq_rd)
                oq_rd_ptr_reg <= ~oq_rd_ptr_reg;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
            oq_mem[oq_wr_ptr_reg] <= bk_res;
    end

    assign new_vel_a_x = oq_head.new_vel_a_x;
    assign new_vel_a_y = oq_head.new_vel_a_y;
    assign new_vel_b_x = oq_head.new_vel_b_x;
    assign new_vel_b_y = oq_head.new_vel_b_y;
    assign skipped     = oq_head.skipped;

endmodule

`default_nettype wire

/* hdl/dci_qmul.sv */
`default_nettype none

module dci_qmul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);
    import dci_pkg::*;

    logic [63:0]        a_mag_reg;
    logic [63:0]        b_mag_reg;
    logic               neg1_reg;
    logic               neg2_reg;
    logic               neg3_reg;
    logic [63:0]        pp0_reg;
    logic [63:0]        pp1_reg;
    logic [63:0]        pp2_reg;
    logic [63:0]        pp3_reg;
    logic [127:0]       prod_reg;
    logic [127:0]       prod_next;
    logic signed [63:0] p_reg;
    logic [63:0]        mag_lo;
    logic               over;
    logic [63:0]        mag_sat;

    // Recombine the partial products, then scale and saturate the magnitude.
    always_comb
    begin
        prod_next = {pp3_reg, pp0_reg} + {32'd0, pp1_reg, 32'd0} + {32'd0, pp2_reg, 32'd0};
        mag_lo    = prod_reg[FRAC_BITS +: 64];
        over      = (|prod_reg[127:FRAC_BITS+64]) | mag_lo[63];
        mag_sat   = over ? S64_MAX : mag_lo;
    end

    // Magnitudes, 32x32 partial products, sum, signed result.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg <= a[63] ? (64'd0 - a) : a;
            b_mag_reg <= b[63] ? (64'd0 - b) : b;
            neg1_reg  <= a[63] ^ b[63];
            pp0_reg   <= a_mag_reg[31:0]  * b_mag_reg[31:0];
            pp1_reg   <= a_mag_reg[31:0]  * b_mag_reg[63:32];
            pp2_reg   <= a_mag_reg[63:32] * b_mag_reg[31:0];
            pp3_reg   <= a_mag_reg[63:32] * b_mag_reg[63:32];
            neg2_reg  <= neg1_reg;
            prod_reg  <= prod_next;
            neg3_reg  <= neg2_reg;
            p_reg     <= neg3_reg ? (64'd0 - mag_sat) : mag_sat;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hdl/dci_qdiv.sv */
`default_nettype none

module dci_qdiv (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] q
);
    import dci_pkg::*;

    localparam int STEPS = 64;

    logic [63:0]        rem_reg [STEPS+1];
    logic [63:0]        lo_reg  [STEPS+1];
    logic [63:0]        q_reg   [STEPS+1];
    logic [63:0]        d_reg   [STEPS+1];
    logic               neg_reg [STEPS+1];
    logic               sat_reg [STEPS+1];
    logic [63:0]        rem_next [STEPS];
    logic [63:0]        q_next   [STEPS];
    logic [64:0]        trem [STEPS];
    logic [64:0]        diff [STEPS];
    logic               ge   [STEPS];
    logic [63:0]        n_mag;
    logic [63:0]        d_mag;
    logic [63:0]        hi;
    logic [63:0]        q_mag;
    logic signed [63:0] q_out_reg;

    // Setup: magnitudes, upper dividend word and the overflow check.
    always_comb
    begin
        n_mag = num[63] ? (64'd0 - num) : num;
        d_mag = den[63] ? (64'd0 - den) : den;
        hi    = n_mag >> (64 - FRAC_BITS);
    end

    // One restoring step per stage, one quotient bit each, MSB first.
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            trem[k]     = {rem_reg[k], lo_reg[k][63]};
            ge[k]       = trem[k] >= {1'b0, d_reg[k]};
            diff[k]     = trem[k] - {1'b0, d_reg[k]};
            rem_next[k] = ge[k] ? diff[k][63:0] : trem[k][63:0];
            q_next[k]   = {q_reg[k][62:0], ge[k]};
        end
    end

    assign q_mag = (sat_reg[STEPS] | q_reg[STEPS][63]) ? S64_MAX : q_reg[STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi;
            lo_reg[0]  <= n_mag << FRAC_BITS;
            q_reg[0]   <= 64'd0;
            d_reg[0]   <= d_mag;
            neg_reg[0] <= num[63] ^ den[63];
            sat_reg[0] <= hi >= d_mag;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                lo_reg[k+1]  <= lo_reg[k] << 1;
                q_reg[k+1]   <= q_next[k];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
            q_out_reg <= neg_reg[STEPS] ? (64'd0 - q_mag) : q_mag;
        end
    end

    assign q = q_out_reg;

endmodule

`default_nettype wire

/* hdl/dci_front.sv */
`default_nettype none

module dci_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] pos_a_x,
    input  logic signed [31:0] pos_a_y,
    input  logic signed [31:0] pos_b_x,
    input  logic signed [31:0] pos_b_y,
    input  logic signed [31:0] vel_a_x,
    input  logic signed [31:0] vel_a_y,
    input  logic signed [31:0] vel_b_x,
    input  logic signed [31:0] vel_b_y,
    input  logic [30:0]        inv_mass_a,
    input  logic [30:0]        inv_mass_b,
    input  logic [30:0]        rest_distance,
    input  logic               take,
    output logic               head_valid,
    output dci_pkg::prep_t     head
);
    import dci_pkg::*;

    prep_t            fq_mem [FQ_DEPTH];
    prep_t            prep;
    logic [FQ_AW-1:0] wr_ptr_reg;
    logic [FQ_AW-1:0] rd_ptr_reg;
    logic [FQ_AW:0]   cnt_reg;
    logic [FQ_AW-1:0] wr_ptr_next;
    logic [FQ_AW-1:0] rd_ptr_next;
    logic [FQ_AW:0]   cnt_next;
    logic             wr;
    logic             rd;

    // Form the exact differences and the inverse mass sum.
    always_comb
    begin
        prep.rx            = {pos_b_x[31], pos_b_x} - {pos_a_x[31], pos_a_x};
        prep.ry            = {pos_b_y[31], pos_b_y} - {pos_a_y[31], pos_a_y};
        prep.dvx           = {vel_b_x[31], vel_b_x} - {vel_a_x[31], vel_a_x};
        prep.dvy           = {vel_b_y[31], vel_b_y} - {vel_a_y[31], vel_a_y};
        prep.vel_a_x       = vel_a_x;
        prep.vel_a_y       = vel_a_y;
        prep.vel_b_x       = vel_b_x;
        prep.vel_b_y       = vel_b_y;
        prep.inv_mass_a    = inv_mass_a;
        prep.inv_mass_b    = inv_mass_b;
        prep.inv_mass_sum  = {1'b0, inv_mass_a} + {1'b0, inv_mass_b};
        prep.rest_distance = rest_distance;
    end

    // Queue bookkeeping.
    assign full       = cnt_reg == (FQ_AW+1)'(FQ_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign wr         = push & ~full;
    assign rd         = take & head_valid;
    assign head       = fq_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (FQ_AW+1)'(wr) - (FQ_AW+1)'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr)
            fq_mem[wr_ptr_reg] <= prep;
    end

endmodule

`default_nettype wire

/* hdl/dci_back.sv */
`default_nettype none

module dci_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  dci_pkg::prep_t in_data,
    input  logic [16:0]    gain,
    input  logic [30:0]    inv_dt,
    output logic           res_valid,
    output dci_pkg::res_t  res
);
    import dci_pkg::*;

    // Stage times, counted in advances after the item leaves the queue.
    localparam int T_P    = MUL_LAT;
    localparam int T_SUM  = T_P + 1;
    localparam int T_C    = T_SUM + 1;
    localparam int T_N0   = T_C + 1;
    localparam int T_GC   = T_C + MUL_LAT;
    localparam int T_CORR = T_GC + MUL_LAT;
    localparam int T_DEN  = T_N0 + MUL_LAT;
    localparam int T_NUM  = T_CORR + 1;
    localparam int T_LAM  = T_NUM + DIV_LAT;
    localparam int T_TP   = T_LAM + MUL_LAT;
    localparam int T_OUT  = T_TP + 1;

    localparam int N_VEL  = T_TP;
    localparam int N_IMS  = T_N0;
    localparam int N_AP   = T_LAM - T_P;
    localparam int N_N0   = T_CORR - T_N0;
    localparam int N_DEN  = T_CORR - T_DEN;
    localparam int N_ZERO = T_TP - T_NUM;

    logic signed [63:0] rx64, ry64, dvx64, dvy64, rx2, ry2;
    logic signed [63:0] ima64, imb64, dist64, gain64, invdt64;
    logic signed [63:0] p_rxx, p_ryy, p_dd, p_jx, p_jy;
    logic signed [63:0] p_ax, p_ay, p_bx, p_by;
    logic signed [63:0] p_gc, p_corr, p_den;
    logic signed [63:0] t_ax, t_ay, t_bx, t_by;
    logic signed [63:0] lam;
    logic signed [63:0] rr_reg, jvh_reg, dd_reg;
    logic signed [63:0] cerr_reg, jv_reg, den2_reg;
    logic signed [63:0] num0_reg, den4_reg;
    logic signed [63:0] num_reg, den_reg;
    logic               zero_reg;
    logic signed [63:0] ims64;
    logic [127:0]       vel_dly  [N_VEL];
    logic [31:0]        ims_dly  [N_IMS];
    logic [255:0]       ap_dly   [N_AP];
    logic [63:0]        n0_dly   [N_N0];
    logic [63:0]        den_dly  [N_DEN];
    logic               zero_dly [N_ZERO];
    logic               vld_reg  [T_OUT];
    logic [127:0]       vel_t;
    logic [255:0]       ap_t;
    logic signed [31:0] va_x, va_y, vb_x, vb_y;
    res_t               res_reg;
    res_t               res_next;

    // Operand extension to the 64-bit working format.
    assign rx64    = {{31{in_data.rx[32]}}, in_data.rx};
    assign ry64    = {{31{in_data.ry[32]}}, in_data.ry};
    assign dvx64   = {{31{in_data.dvx[32]}}, in_data.dvx};
    assign dvy64   = {{31{in_data.dvy[32]}}, in_data.dvy};
    assign rx2     = {{30{in_data.rx[32]}}, in_data.rx, 1'b0};
    assign ry2     = {{30{in_data.ry[32]}}, in_data.ry, 1'b0};
    assign ima64   = {33'd0, in_data.inv_mass_a};
    assign imb64   = {33'd0, in_data.inv_mass_b};
    assign dist64  = {33'd0, in_data.rest_distance};
    assign gain64  = {47'd0, gain};
    assign invdt64 = {33'd0, inv_dt};
    assign ims64   = {32'd0, ims_dly[N_IMS-1]};

    // Products taken straight from the queue head.
    dci_qmul u_rxx (.clk(clk), .en(adv), .a(rx64),  .b(rx64),   .p(p_rxx));
    dci_qmul u_ryy (.clk(clk), .en(adv), .a(ry64),  .b(ry64),   .p(p_ryy));
    dci_qmul u_dd  (.clk(clk), .en(adv), .a(dist64), .b(dist64), .p(p_dd));
    dci_qmul u_jx  (.clk(clk), .en(adv), .a(rx64),  .b(dvx64),  .p(p_jx));
    dci_qmul u_jy  (.clk(clk), .en(adv), .a(ry64),  .b(dvy64),  .p(p_jy));
    dci_qmul u_ax  (.clk(clk), .en(adv), .a(rx2),   .b(ima64),  .p(p_ax));
    dci_qmul u_ay  (.clk(clk), .en(adv), .a(ry2),   .b(ima64),  .p(p_ay));
    dci_qmul u_bx  (.clk(clk), .en(adv), .a(rx2),   .b(imb64),  .p(p_bx));
    dci_qmul u_by  (.clk(clk), .en(adv), .a(ry2),   .b(imb64),  .p(p_by));

    // Positional correction and effective mass.
    dci_qmul u_gc   (.clk(clk), .en(adv), .a(gain64),   .b(cerr_reg), .p(p_gc));
    dci_qmul u_corr (.clk(clk), .en(adv), .a(p_gc),     .b(invdt64),  .p(p_corr));
    dci_qmul u_den  (.clk(clk), .en(adv), .a(den4_reg), .b(ims64),    .p(p_den));

    // Impulse magnitude.
    dci_qdiv u_div (.clk(clk), .en(adv), .num(num_reg), .den(den_reg), .q(lam));

    // Velocity changes.
    assign ap_t = ap_dly[N_AP-1];
    dci_qmul u_tax (.clk(clk), .en(adv), .a(ap_t[255:192]), .b(lam), .p(t_ax));
    dci_qmul u_tay (.clk(clk), .en(adv), .a(ap_t[191:128]), .b(lam), .p(t_ay));
    dci_qmul u_tbx (.clk(clk), .en(adv), .a(ap_t[127:64]),  .b(lam), .p(t_bx));
    dci_qmul u_tby (.clk(clk), .en(adv), .a(ap_t[63:0]),    .b(lam), .p(t_by));

    // Output stage: apply the impulse, or pass velocities on a zero denominator.
    assign vel_t = vel_dly[N_VEL-1];
    assign va_x  = vel_t[127:96];
    assign va_y  = vel_t[95:64];
    assign vb_x  = vel_t[63:32];
    assign vb_y  = vel_t[31:0];

    always_comb
    begin
        res_next.skipped = zero_dly[N_ZERO-1];
        if (zero_dly[N_ZERO-1])
        begin
            res_next.new_vel_a_x = va_x;
            res_next.new_vel_a_y = va_y;
            res_next.new_vel_b_x = vb_x;
            res_next.new_vel_b_y = vb_y;
        end
        else
        begin
            res_next.new_vel_a_x = clamp32({{33{va_x[31]}}, va_x} - {t_ax[63], t_ax});
            res_next.new_vel_a_y = clamp32({{33{va_y[31]}}, va_y} - {t_ay[63], t_ay});
            res_next.new_vel_b_x = clamp32({{33{vb_x[31]}}, vb_x} + {t_bx[63], t_bx});
            res_next.new_vel_b_y = clamp32({{33{vb_y[31]}}, vb_y} + {t_by[63], t_by});
        end
    end

    // Scalar datapath stages and the delay lines that keep items aligned.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rr_reg   <= sat_add(p_rxx, p_ryy);
            jvh_reg  <= sat_add(p_jx, p_jy);
            dd_reg   <= p_dd;
            cerr_reg <= sat_sub(rr_reg, dd_reg);
            jv_reg   <= sat_add(jvh_reg, jvh_reg);
            den2_reg <= sat_add(rr_reg, rr_reg);
            num0_reg <= sat_sub(64'sd0, jv_reg);
            den4_reg <= sat_add(den2_reg, den2_reg);
            num_reg  <= sat_sub(n0_dly[N_N0-1], p_corr);
            den_reg  <= den_dly[N_DEN-1];
            zero_reg <= den_dly[N_DEN-1] == 64'd0;
            res_reg  <= res_next;

            vel_dly[0]  <= {in_data.vel_a_x, in_data.vel_a_y,
                            in_data.vel_b_x, in_data.vel_b_y};
            ims_dly[0]  <= in_data.inv_mass_sum;
            ap_dly[0]   <= {p_ax, p_ay, p_bx, p_by};
            n0_dly[0]   <= num0_reg;
            den_dly[0]  <= p_den;
            zero_dly[0] <= zero_reg;
            for (int i = 1; i < N_VEL; i++)
                vel_dly[i] <= vel_dly[i-1];
            for (int i = 1; i < N_IMS; i++)
                ims_dly[i] <= ims_dly[i-1];
            for (int i = 1; i < N_AP; i++)
                ap_dly[i] <= ap_dly[i-1];
            for (int i = 1; i < N_N0; i++)
                n0_dly[i] <= n0_dly[i-1];
            for (int i = 1; i < N_DEN; i++)
                den_dly[i] <= den_dly[i-1];
            for (int i = 1; i < N_ZERO; i++)
                zero_dly[i] <= zero_dly[i-1];
        end
    end

    // Valid bits travel beside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < T_OUT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < T_OUT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign res_valid = vld_reg[T_OUT-1];
    assign res       = res_reg;

endmodule

`default_nettype wire
